>>> sv/efd_pkg.sv
package efd_pkg;

  localparam int unsigned MAX_RAW_BYTES_DEF = 64;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_START_BYTE  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_END_BYTE    = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_ESCAPE_BYTE = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_CRC_SEED    = 3'd3;

  localparam logic [7:0]  START_BYTE_RST  = 8'd1;
  localparam logic [7:0]  END_BYTE_RST    = 8'd4;
  localparam logic [7:0]  ESCAPE_BYTE_RST = 8'd16;
  localparam logic [15:0] CRC_SEED_RST    = 16'd0;

  localparam logic [5:0] PAYLOAD_CNT_MAX = 6'd63;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_FRAME = 2'd1,
    PH_ESC   = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_START = 3'd1,
    ST_CRC       = 3'd2,
    ST_SHORT     = 3'd3,
    ST_OVERFLOW  = 3'd4
  } status_t;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_REPORT  = 1'b1
  } kind_t;

  typedef struct packed {
    logic [7:0]  start_byte;
    logic [7:0]  end_byte;
    logic [7:0]  escape_byte;
    logic [15:0] crc_seed;
  } cfg_t;

  // CRC-16 (poly 0x1021) nibble table
  function automatic logic [15:0] crc_nib(input logic [3:0] k);
    logic [15:0] v;
    case (k)
      4'h0: v = 16'h0000;
      4'h1: v = 16'h1021;
      4'h2: v = 16'h2042;
      4'h3: v = 16'h3063;
      4'h4: v = 16'h4084;
      4'h5: v = 16'h50a5;
      4'h6: v = 16'h60c6;
      4'h7: v = 16'h70e7;
      4'h8: v = 16'h8108;
      4'h9: v = 16'h9129;
      4'ha: v = 16'ha14a;
      4'hb: v = 16'hb16b;
      4'hc: v = 16'hc18c;
      4'hd: v = 16'hd1ad;
      4'he: v = 16'he1ce;
      4'hf: v = 16'hf1ef;
      default: v = 16'h0000;
    endcase
    return v;
  endfunction

  // Fold one byte, high nibble first
  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc_nib(crc[15:12] ^ b[7:4]) ^ {crc[11:0], 4'h0};
    c = crc_nib(c[15:12] ^ b[3:0]) ^ {c[11:0], 4'h0};
    return c;
  endfunction

endpackage

>>> sv/efd_rx_if.sv
interface efd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

>>> sv/efd_res_if.sv
interface efd_res_if;
  logic             valid;
  logic             ready;
  efd_pkg::kind_t   result_kind;
  logic [7:0]       payload_byte;
  efd_pkg::status_t frame_status;
  logic [5:0]       frame_length;

  modport source (output valid, output result_kind, output payload_byte,
                  output frame_status, output frame_length, input ready);
  modport sink (input valid, input result_kind, input payload_byte,
                input frame_status, input frame_length, output ready);
endinterface

>>> sv/efd_cfg_if.sv
interface efd_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [efd_pkg::CFG_ADDR_W-1:0]  addr;
  logic [efd_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output addr, output data, input ready);
  modport sink (input valid, input addr, input data, output ready);
endinterface

>>> sv/escaped_frame_decoder_crc16.sv
// Channel  Dir  Words carried                                   Handshake
// in_ch    in   rx_byte (8b raw link byte)                      valid/ready
// out_ch   out  result_kind, payload_byte, frame_status,        valid/ready
//               frame_length
// cfg_ch   in   addr (register index), data (16b write value)   valid/ready, ready tied high
//
// One word per cycle while the output is not stalled: a raw byte sits in the
// input register while the decode step works on it, and any result it yields
// lands in the output register at the next edge.
// Reset (rst_n low, synchronous) clears the handshake flags, phase and counters
// and loads the register defaults; no clearing pass is needed.
// A stalled output holds the decode step; once the output and input registers
// are both full, in_ch.ready drops, so at most two words are in flight.
module escaped_frame_decoder_crc16 #(
  parameter int unsigned MAX_RAW_BYTES = efd_pkg::MAX_RAW_BYTES_DEF
) (
  input logic       clk,
  input logic       rst_n,
  efd_rx_if.sink    in_ch,
  efd_res_if.source out_ch,
  efd_cfg_if.sink   cfg_ch
);
  import efd_pkg::*;

  cfg_t       cfg;
  logic       byte_v;
  logic [7:0] byte_d;
  logic       advance;

  // Register file: start, end and escape act at once, seed at the next start
  efd_cfg_regs u_cfg_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  // Input register: hold one raw word until the decode step takes it
  efd_in_stage u_in_stage (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .advance (advance),
    .byte_v  (byte_v),
    .byte_d  (byte_d)
  );

  // Decode step: unescape, two-byte delay, CRC fold, frame report,
  // followed by the result register
  efd_decoder #(
    .MAX_RAW_BYTES (MAX_RAW_BYTES)
  ) u_decoder (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .byte_v  (byte_v),
    .byte_d  (byte_d),
    .advance (advance),
    .out_ch  (out_ch)
  );

endmodule

>>> sv/efd_cfg_regs.sv
module efd_cfg_regs (
  input  logic          clk,
  input  logic          rst_n,
  efd_cfg_if.sink       cfg_ch,
  output efd_pkg::cfg_t cfg
);
  import efd_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ch.ready = 1'b1;
  assign cfg = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.addr)
        CFG_START_BYTE:  cfg_nxt.start_byte  = cfg_ch.data[7:0];
        CFG_END_BYTE:    cfg_nxt.end_byte    = cfg_ch.data[7:0];
        CFG_ESCAPE_BYTE: cfg_nxt.escape_byte = cfg_ch.data[7:0];
        CFG_CRC_SEED:    cfg_nxt.crc_seed    = cfg_ch.data[15:0];
        default:         cfg_nxt = cfg_r;  // drop writes to unused indexes
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_byte  <= START_BYTE_RST;
      cfg_r.end_byte    <= END_BYTE_RST;
      cfg_r.escape_byte <= ESCAPE_BYTE_RST;
      cfg_r.crc_seed    <= CRC_SEED_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

>>> sv/efd_in_stage.sv
module efd_in_stage (
  input  logic       clk,
  input  logic       rst_n,
  efd_rx_if.sink     in_ch,
  input  logic       advance,
  output logic       byte_v,
  output logic [7:0] byte_d
);

  logic       v_r;
  logic       v_nxt;
  logic [7:0] byte_r;

  // Take a new word whenever the slot is empty or drains this cycle
  assign in_ch.ready = !v_r || advance;
  assign byte_v = v_r;
  assign byte_d = byte_r;

  always_comb begin
    v_nxt = v_r;
    if (in_ch.valid && in_ch.ready) begin
      v_nxt = 1'b1;
    end else if (advance) begin
      v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      byte_r <= in_ch.rx_byte;
    end
  end

endmodule

>>> sv/efd_decoder.sv
module efd_decoder #(
  parameter int unsigned MAX_RAW_BYTES = efd_pkg::MAX_RAW_BYTES_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  efd_pkg::cfg_t cfg,
  input  logic          byte_v,
  input  logic [7:0]    byte_d,
  output logic          advance,
  efd_res_if.source     out_ch
);
  import efd_pkg::*;

  localparam int unsigned RAW_W = $clog2(MAX_RAW_BYTES);
  localparam logic [RAW_W-1:0] RAW_LIMIT = RAW_W'(MAX_RAW_BYTES - 1);

  phase_t           phase_r, phase_nxt;
  logic [7:0]       held0_r, held0_nxt;
  logic [7:0]       held1_r, held1_nxt;
  logic [1:0]       held_cnt_r, held_cnt_nxt;
  logic [15:0]      crc_r, crc_nxt;
  logic [RAW_W-1:0] raw_cnt_r, raw_cnt_nxt;
  logic [5:0]       pay_cnt_r, pay_cnt_nxt;

  logic             out_v_r;
  kind_t            kind_r;
  logic [7:0]       pbyte_r;
  status_t          status_r;
  logic [5:0]       len_r;

  logic             res_v;
  kind_t            res_kind;
  logic [7:0]       res_byte;
  status_t          res_status;
  logic [5:0]       res_len;

  logic is_start, is_end, is_esc, at_limit;

  // Process a word when the result register is free or draining
  assign advance  = byte_v && (!out_v_r || out_ch.ready);
  assign is_start = (byte_d == cfg.start_byte);
  assign is_end   = (byte_d == cfg.end_byte);
  assign is_esc   = (byte_d == cfg.escape_byte);
  assign at_limit = (raw_cnt_r >= RAW_LIMIT);

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    if (advance) begin
      case (phase_r)
        PH_FRAME, PH_ESC: begin
          if (phase_r == PH_FRAME && is_end) begin
            phase_nxt = PH_IDLE;
          end else if (at_limit) begin
            phase_nxt = PH_IDLE;
          end else if (phase_r == PH_FRAME && is_esc) begin
            phase_nxt = PH_ESC;
          end else begin
            phase_nxt = PH_FRAME;
          end
        end
        default: phase_nxt = is_start ? PH_FRAME : PH_IDLE;
      endcase
    end
  end

  // Datapath and result
  always_comb begin
    held0_nxt    = held0_r;
    held1_nxt    = held1_r;
    held_cnt_nxt = held_cnt_r;
    crc_nxt      = crc_r;
    raw_cnt_nxt  = raw_cnt_r;
    pay_cnt_nxt  = pay_cnt_r;
    res_v        = 1'b0;
    res_kind     = KIND_REPORT;
    res_byte     = 8'd0;
    res_status   = ST_OK;
    res_len      = 6'd0;
    if (advance) begin
      case (phase_r)
        PH_FRAME, PH_ESC: begin
          if (phase_r == PH_FRAME && is_end) begin
            res_v = 1'b1;
            if (held_cnt_r < 2'd2) begin
              res_status = ST_SHORT;
            end else begin
              res_status = ({held1_r, held0_r} == crc_r) ? ST_OK : ST_CRC;
              res_len    = pay_cnt_r;
            end
          end else if (at_limit) begin
            res_v      = 1'b1;
            res_status = ST_OVERFLOW;
            res_len    = pay_cnt_r;
          end else begin
            raw_cnt_nxt = raw_cnt_r + RAW_W'(1);
            if (phase_r == PH_FRAME && is_esc) begin
              // escape itself is dropped
            end else if (held_cnt_r < 2'd2) begin
              if (held_cnt_r[0]) begin
                held1_nxt = byte_d;
              end else begin
                held0_nxt = byte_d;
              end
              held_cnt_nxt = held_cnt_r + 2'd1;
            end else begin
              held0_nxt = held1_r;
              held1_nxt = byte_d;
              crc_nxt   = crc_fold(crc_r, held0_r);
              if (pay_cnt_r < PAYLOAD_CNT_MAX) begin
                pay_cnt_nxt = pay_cnt_r + 6'd1;
              end
              res_v    = 1'b1;
              res_kind = KIND_PAYLOAD;
              res_byte = held0_r;
            end
          end
        end
        default: begin
          if (is_start) begin
            held_cnt_nxt = 2'd0;
            crc_nxt      = cfg.crc_seed;
            raw_cnt_nxt  = RAW_W'(1);
            pay_cnt_nxt  = 6'd0;
          end else begin
            res_v      = 1'b1;
            res_status = ST_BAD_START;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      held_cnt_r <= 2'd0;
      raw_cnt_r  <= '0;
      pay_cnt_r  <= 6'd0;
      out_v_r    <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      held_cnt_r <= held_cnt_nxt;
      raw_cnt_r  <= raw_cnt_nxt;
      pay_cnt_r  <= pay_cnt_nxt;
      if (advance) begin
        out_v_r <= res_v;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    held0_r <= held0_nxt;
    held1_r <= held1_nxt;
    crc_r   <= crc_nxt;
    if (advance && res_v) begin
      kind_r   <= res_kind;
      pbyte_r  <= res_byte;
      status_r <= res_status;
      len_r    <= res_len;
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.result_kind  = kind_r;
  assign out_ch.payload_byte = pbyte_r;
  assign out_ch.frame_status = status_r;
  assign out_ch.frame_length = len_r;

endmodule
